[rtl/tkft_pkg.sv]
// ----------------------------------------------------------------------------
// tkft_pkg
// Shared widths, mode codes and the per-cell control word of the top-k
// frequency tracker.
// ----------------------------------------------------------------------------
package tkft_pkg;

  // Field widths of the input and result words
  localparam int MODE_W    = 2;
  localparam int ID_W      = 12;
  localparam int SLOT_W    = 4;
  localparam int OUT_CNT_W = 24;
  localparam int OUT_POS_W = 4;

  // Operation codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Per-cell update command from the list controller
  typedef struct packed {
    logic clear;  // empty the cell
    logic load;   // take the new id and count
    logic shift;  // take the entry of the cell one rank above
  } tkft_cell_ctl_t;

endpackage

[rtl/tkft_if.sv]
// ----------------------------------------------------------------------------
// tkft_in_if / tkft_out_if
// Valid/ready channels for the request word and the result word.
// ----------------------------------------------------------------------------
interface tkft_in_if;
  import tkft_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   location_id;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, output mode, output location_id, output slot_index,
                  input ready);
  modport sink   (input valid, input mode, input location_id, input slot_index,
                  output ready);
endinterface

interface tkft_out_if;
  import tkft_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ID_W-1:0]      out_location;
  logic [OUT_CNT_W-1:0] out_count;
  logic [OUT_POS_W-1:0] out_position;
  logic                 entry_valid;
  logic                 list_full;

  modport source (output valid, output out_location, output out_count,
                  output out_position, output entry_valid, output list_full,
                  input ready);
  modport sink   (input valid, input out_location, input out_count,
                  input out_position, input entry_valid, input list_full,
                  output ready);
endinterface

[rtl/tkft_ram.sv]
// ----------------------------------------------------------------------------
// tkft_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tkft_ram #(
  parameter  int WIDTH = 24,
  parameter  int DEPTH = 4096,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/tkft_cell.sv]
// ----------------------------------------------------------------------------
// tkft_cell
// One rank slot of the sorted list: holds an id, its count and a valid bit,
// compares itself against the probed id and count, and takes the entry of
// its upper neighbor when the list shifts down.
// ----------------------------------------------------------------------------
module tkft_cell #(
  parameter int COUNT_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tkft_pkg::tkft_cell_ctl_t    ctl,
  input  logic [tkft_pkg::ID_W-1:0]   new_id,
  input  logic [COUNT_BITS-1:0]       new_count,
  input  logic [tkft_pkg::ID_W-1:0]   left_id,
  input  logic [COUNT_BITS-1:0]       left_count,
  input  logic                        left_valid,
  input  logic [tkft_pkg::ID_W-1:0]   probe_id,
  input  logic [COUNT_BITS-1:0]       probe_count,
  input  logic                        probe_sat,
  output logic [tkft_pkg::ID_W-1:0]   id,
  output logic [COUNT_BITS-1:0]       count,
  output logic                        valid,
  output logic                        match,
  output logic                        ahead
);
  import tkft_pkg::*;

  logic [ID_W-1:0]       id_r;
  logic [ID_W-1:0]       id_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;
  logic                  valid_r;
  logic                  valid_nxt;

  // Select the next entry: clear, load the new one, shift from above, or hold
  always_comb begin
    id_nxt    = id_r;
    count_nxt = count_r;
    valid_nxt = valid_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.load) begin
      id_nxt    = new_id;
      count_nxt = new_count;
      valid_nxt = 1'b1;
    end else if (ctl.shift) begin
      id_nxt    = left_id;
      count_nxt = left_count;
      valid_nxt = left_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    count_r <= count_nxt;
  end

  // An entry stays ahead of the incremented id when its count is not beaten;
  // a saturated count never beats anything
  assign match = valid_r && (id_r == probe_id);
  assign ahead = valid_r && (probe_sat ? (count_r >= probe_count)
                                       : (count_r > probe_count));

  assign id    = id_r;
  assign count = count_r;
  assign valid = valid_r;

endmodule

[rtl/top_k_frequency_tracker_unit.sv]
// Add, read and unused-mode words: count memory read on acceptance, list compare
// in the fetch state, list shift and result register in the update state, which
// stalls while a result is held; no word is taken before the update. A clear
// word sweeps the count memory one entry per cycle through its write port first.
// Reset (synchronous, active low) empties the list and starts the same sweep;
// in_ch.ready stays low until the sweep has ended.
// ----------------------------------------------------------------------------
// top_k_frequency_tracker_unit
// Exact per-location hit counter with a sorted list of the RANK_SIZE most
// frequent locations, kept in a chain of rank cells.
// ----------------------------------------------------------------------------
module top_k_frequency_tracker_unit #(
  parameter int LOCATION_COUNT = 4096,
  parameter int RANK_SIZE      = 10,
  parameter int COUNT_BITS     = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  tkft_in_if.sink    in_ch,
  tkft_out_if.source out_ch
);
  import tkft_pkg::*;

  localparam int ADDR_W = $clog2(LOCATION_COUNT);
  localparam int POS_W  = $clog2(RANK_SIZE + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [ADDR_W-1:0]     LAST_ADDR  = ADDR_W'(LOCATION_COUNT - 1);
  localparam logic [POS_W-1:0]      LAST_RANK  = POS_W'(RANK_SIZE - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FETCH  = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_SWEEP  = 4'b1000
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic [ADDR_W-1:0]   clr_ptr_r;
  logic [ADDR_W-1:0]   clr_ptr_nxt;
  logic                reply_r;
  logic                reply_nxt;

  // Held request word
  logic [MODE_W-1:0]   mode_r;
  logic [ID_W-1:0]     id_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [ADDR_W-1:0]   addr_r;
  logic                in_range_r;

  // Compare results latched for the list update
  logic [COUNT_BITS-1:0] cnt_r;
  logic [RANK_SIZE-1:0]  match_r;
  logic [RANK_SIZE-1:0]  ahead_r;

  // Result register
  logic                 out_valid_r;
  logic [ID_W-1:0]      out_loc_r;
  logic [OUT_CNT_W-1:0] out_cnt_r;
  logic [OUT_POS_W-1:0] out_pos_r;
  logic                 out_ev_r;
  logic                 out_full_r;

  logic                  in_fire;
  logic                  upd_fire;
  logic                  add_ok;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic                  old_sat;
  logic [COUNT_BITS-1:0] cnt_new;

  logic [ID_W-1:0]       cell_id    [RANK_SIZE];
  logic [COUNT_BITS-1:0] cell_cnt   [RANK_SIZE];
  logic [ID_W-1:0]       left_id    [RANK_SIZE];
  logic [COUNT_BITS-1:0] left_cnt   [RANK_SIZE];
  logic [RANK_SIZE-1:0]  left_vld;
  logic [RANK_SIZE-1:0]  cell_vld;
  logic [RANK_SIZE-1:0]  cell_match;
  logic [RANK_SIZE-1:0]  cell_ahead;
  logic [RANK_SIZE-1:0]  ahead_nxt;
  tkft_cell_ctl_t        cell_ctl   [RANK_SIZE];

  logic                 hit;
  logic [POS_W-1:0]     new_pos;
  logic [POS_W-1:0]     hit_pos;
  logic [POS_W-1:0]     shift_end;
  logic                 full_nxt;

  logic [ID_W-1:0]      res_loc;
  logic [OUT_CNT_W-1:0] res_cnt;
  logic [OUT_POS_W-1:0] res_pos;
  logic                 res_ev;
  logic                 res_full;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign upd_fire    = (state_r == ST_UPDATE) && (!out_valid_r || out_ch.ready);
  assign add_ok      = (mode_r == MODE_ADD) && in_range_r;

  // Sequence: fetch count, compare the list, then shift it; sweep on clear
  always_comb begin
    state_nxt   = state_r;
    clr_ptr_nxt = clr_ptr_r;
    reply_nxt   = reply_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.mode == MODE_CLEAR) begin
            state_nxt   = ST_SWEEP;
            clr_ptr_nxt = '0;
            reply_nxt   = 1'b1;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        clr_ptr_nxt = clr_ptr_r + 1'b1;
        if (clr_ptr_r == LAST_ADDR) begin
          state_nxt = reply_r ? ST_UPDATE : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_SWEEP;
      clr_ptr_r <= '0;
      reply_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_ptr_r <= clr_ptr_nxt;
      reply_r   <= reply_nxt;
    end
  end

  // Hold the accepted request word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r     <= in_ch.mode;
      id_r       <= in_ch.location_id;
      slot_r     <= in_ch.slot_index;
      addr_r     <= ADDR_W'(32'(in_ch.location_id));
      in_range_r <= (32'(in_ch.location_id) < LOCATION_COUNT);
    end
  end

  // Count memory: read on accept, write the bumped count or sweep zeros
  assign old_sat   = (ram_rdata == COUNT_MAX);
  assign cnt_new   = old_sat ? ram_rdata : ram_rdata + 1'b1;
  assign ram_we    = (state_r == ST_SWEEP) || ((state_r == ST_FETCH) && add_ok);
  assign ram_waddr = (state_r == ST_SWEEP) ? clr_ptr_r : addr_r;
  assign ram_wdata = (state_r == ST_SWEEP) ? '0 : cnt_new;

  tkft_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (LOCATION_COUNT)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_fire),
    .rd_addr (ADDR_W'(32'(in_ch.location_id))),
    .rd_data (ram_rdata)
  );

  // Chain of rank cells; cell 0 has no upper neighbor
  for (genvar i = 0; i < RANK_SIZE; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_id[i]  = '0;
      assign left_cnt[i] = '0;
      assign left_vld[i] = 1'b0;
    end else begin : g_link
      assign left_id[i]  = cell_id[i-1];
      assign left_cnt[i] = cell_cnt[i-1];
      assign left_vld[i] = cell_vld[i-1];
    end

    tkft_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (cell_ctl[i]),
      .new_id      (id_r),
      .new_count   (cnt_r),
      .left_id     (left_id[i]),
      .left_count  (left_cnt[i]),
      .left_valid  (left_vld[i]),
      .probe_id    (id_r),
      .probe_count (ram_rdata),
      .probe_sat   (old_sat),
      .id          (cell_id[i]),
      .count       (cell_cnt[i]),
      .valid       (cell_vld[i]),
      .match       (cell_match[i]),
      .ahead       (cell_ahead[i])
    );
  end

  // A listed id only counts the entries above its own slot
  always_comb begin
    for (int i = 0; i < RANK_SIZE; i++) begin
      ahead_nxt[i] = cell_ahead[i] &&
                     (!(|cell_match) || ((cell_match >> (i + 1)) != '0));
    end
  end

  // Latch the bumped count and the compare vectors
  always_ff @(posedge clk) begin
    if (state_r == ST_FETCH) begin
      cnt_r   <= cnt_new;
      match_r <= cell_match;
      ahead_r <= ahead_nxt;
    end
  end

  // New rank is the number of entries that stay ahead
  always_comb begin
    new_pos = '0;
    hit_pos = '0;
    for (int i = 0; i < RANK_SIZE; i++) begin
      new_pos = new_pos + POS_W'(ahead_r[i]);
      if (match_r[i]) begin
        hit_pos = POS_W'(i);
      end
    end
  end

  assign hit       = |match_r;
  assign shift_end = hit ? hit_pos : LAST_RANK;
  assign full_nxt  = cell_vld[RANK_SIZE-1] ||
                     (upd_fire && add_ok && !hit && (new_pos == LAST_RANK));

  // Cells: clear on a clear word, load at the new rank, shift the span below it
  always_comb begin
    for (int i = 0; i < RANK_SIZE; i++) begin
      cell_ctl[i].clear = in_fire && (in_ch.mode == MODE_CLEAR);
      cell_ctl[i].load  = upd_fire && add_ok && (POS_W'(i) == new_pos);
      cell_ctl[i].shift = upd_fire && add_ok && (POS_W'(i) > new_pos) &&
                          (POS_W'(i) <= shift_end);
    end
  end

  // Build the result word
  always_comb begin
    res_loc  = '0;
    res_cnt  = '0;
    res_pos  = '0;
    res_ev   = 1'b0;
    res_full = cell_vld[RANK_SIZE-1];
    case (mode_r)
      MODE_ADD: begin
        res_loc  = id_r;
        res_full = full_nxt;
        if (in_range_r) begin
          res_cnt = OUT_CNT_W'(32'(cnt_r));
          res_pos = OUT_POS_W'(32'(new_pos));
          res_ev  = 1'b1;
        end else begin
          res_pos = OUT_POS_W'(RANK_SIZE);
        end
      end
      MODE_READ: begin
        res_pos = slot_r;
        for (int i = 0; i < RANK_SIZE; i++) begin
          if ((32'(slot_r) == i) && cell_vld[i]) begin
            res_loc = cell_id[i];
            res_cnt = OUT_CNT_W'(32'(cell_cnt[i]));
            res_ev  = 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        res_full = 1'b0;
      end
      default: begin
        res_full = cell_vld[RANK_SIZE-1];
      end
    endcase
  end

  // Output register: load on update, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_loc_r  <= res_loc;
      out_cnt_r  <= res_cnt;
      out_pos_r  <= res_pos;
      out_ev_r   <= res_ev;
      out_full_r <= res_full;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_location = out_loc_r;
  assign out_ch.out_count    = out_cnt_r;
  assign out_ch.out_position = out_pos_r;
  assign out_ch.entry_valid  = out_ev_r;
  assign out_ch.list_full    = out_full_r;

endmodule

[rtl/tkft_checker.sv]
// ----------------------------------------------------------------------------
// tkft_checker
// Port-level checks of the top-k frequency tracker, bound to the top level.
// ----------------------------------------------------------------------------
module tkft_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [tkft_pkg::ID_W-1:0]      out_location,
  input logic [tkft_pkg::OUT_CNT_W-1:0] out_count,
  input logic [tkft_pkg::OUT_POS_W-1:0] out_position,
  input logic                           out_entry_valid,
  input logic                           out_list_full
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_location, out_count, out_position, out_entry_valid, out_list_full}))
    else $error("result word changed while stalled");

  // One word at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted on back-to-back cycles");

  // An invalid result never carries a count
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_count == '0)
    else $error("count reported on an invalid result");

  // Reset starts the memory sweep, so no request is taken right after it
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request port open during clearing sweep");

endmodule

bind top_k_frequency_tracker_unit tkft_checker u_tkft_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_location    (out_ch.out_location),
  .out_count       (out_ch.out_count),
  .out_position    (out_ch.out_position),
  .out_entry_valid (out_ch.entry_valid),
  .out_list_full   (out_ch.list_full)
);
